### rtl/core/lri_pkg.sv
// Package for the line/rectangle intersection test.
// Holds default widths; no dependencies.
package lri_pkg;
	localparam int COORD_BITS_DEF = 16;
endpackage

### rtl/core/lri_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cycle.
// Depends on lri_pkg for defaults only.
module lri_div_cell #(
	parameter int NB = 36,
	parameter int DB = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NB-1:0] in_q,
	input  logic [NB:0]   in_r,
	input  logic [DB-1:0] in_d,
	output logic          out_vld,
	output logic [NB-1:0] out_q,
	output logic [NB:0]   out_r,
	output logic [DB-1:0] out_d
);
	import lri_pkg::*;
	logic [NB:0] sh;
	logic [NB:0] df;
	logic [NB:0] dx;

	// shift in next dividend bit and trial subtract
	assign sh = {in_r[NB-1:0], in_q[NB-1]};
	assign dx = {{(NB+1-DB){1'b0}}, in_d};
	assign df = sh - dx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_d <= in_d;
		if (sh >= dx) begin
			out_r <= df;
			out_q <= {in_q[NB-2:0], 1'b1};
		end else begin
			out_r <= sh;
			out_q <= {in_q[NB-2:0], 1'b0};
		end
	end
endmodule

### rtl/core/lri_edge.sv
// One edge lane: magnitude divide through a cell chain, then sign fix and span test.
// Depends on lri_pkg and lri_div_cell.
module lri_edge #(
	parameter int NB = 36,
	parameter int DB = 18,
	parameter int CB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [NB-1:0] num,
	input  logic signed [DB-1:0] den,
	input  logic signed [CB-1:0] lo,
	input  logic signed [CB-1:0] hi,
	input  logic                 en,
	output logic                 out_vld,
	output logic                 hit
);
	import lri_pkg::*;
	logic [NB-1:0] q [NB+1];
	logic [NB:0]   r [NB+1];
	logic [DB-1:0] d [NB+1];
	logic          v [NB+1];
	// sideband delay line: sign, enable and bounds
	logic          neg_q [NB+1];
	logic          en_q  [NB+1];
	logic signed [CB-1:0] lo_q [NB+1];
	logic signed [CB-1:0] hi_q [NB+1];
	logic signed [NB:0] qs;

	assign v[0] = in_vld;
	assign q[0] = num[NB-1] ? NB'(-num) : NB'(num);
	assign r[0] = '0;
	assign d[0] = den[DB-1] ? DB'(-den) : DB'(den);
	assign neg_q[0] = num[NB-1] ^ den[DB-1];
	assign en_q[0] = en && (den != '0);
	assign lo_q[0] = lo;
	assign hi_q[0] = hi;

	for (genvar i = 0; i < NB; i++) begin : g_cell
		lri_div_cell #(.NB(NB), .DB(DB)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_vld(v[i]), .in_q(q[i]), .in_r(r[i]), .in_d(d[i]),
			.out_vld(v[i+1]), .out_q(q[i+1]), .out_r(r[i+1]), .out_d(d[i+1])
		);
		always_ff @(posedge clk) begin
			neg_q[i+1] <= neg_q[i];
			en_q[i+1]  <= en_q[i];
			lo_q[i+1]  <= lo_q[i];
			hi_q[i+1]  <= hi_q[i];
		end
	end

	// signed truncated quotient and inclusive span test, only for a live request
	assign qs = neg_q[NB] ? -$signed({1'b0, q[NB]}) : $signed({1'b0, q[NB]});
	assign out_vld = v[NB];
	assign hit = out_vld && en_q[NB] && (qs >= (NB+1)'(lo_q[NB]))
		&& (qs <= (NB+1)'(hi_q[NB]));
endmodule

### rtl/core/line_rect_intersect_test_top.sv
// Top level of the line/rectangle intersection test.
// Depends on lri_pkg, lri_edge, lri_div_cell.
// A request is taken in any cycle that busy is low (busy is tied low): one request per
// cycle. Each result passes one input register, one product register (the numerators
// are summed from it combinationally), then one cell per quotient bit of the divider
// chain, with done high for exactly one cycle. The receiver cannot stall the block.
module line_rect_intersect_test_top #(
	parameter int COORD_BITS = lri_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] line_a_x,
	input  logic signed [COORD_BITS-1:0] line_a_y,
	input  logic signed [COORD_BITS-1:0] line_b_x,
	input  logic signed [COORD_BITS-1:0] line_b_y,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic signed [COORD_BITS-1:0] rect_right,
	input  logic signed [COORD_BITS-1:0] rect_bottom,
	output logic                         done,
	output logic                         hit
);
	import lri_pkg::*;
	localparam int CB = COORD_BITS;
	localparam int DB = CB + 1;
	localparam int PB = 2 * CB + 2;
	localparam int NB = 2 * CB + 4;

	logic signed [CB-1:0] ax_s1, ay_s1, l_s1, t_s1, r_s1, b_s1;
	logic signed [DB-1:0] a1_s1, b1_s1;
	logic                 v_s1, v_s2;
	logic signed [PB-1:0] p_ax_s2, p_b1t_s2, p_b1b_s2, p_b1y_s2, p_a1l_s2, p_a1r_s2;
	logic signed [NB-1:0] nxt, nxb, nyl, nyr;
	logic signed [DB-1:0] a1_s2, b1_s2;
	logic signed [CB-1:0] l_s2, t_s2, r_s2, b_s2;
	logic                 eh_s2, ev_s2;
	logic [3:0]           ov, oh;

	assign busy = 1'b0;

	// stage 1: register inputs, form line coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= line_a_x;  ay_s1 <= line_a_y;
		l_s1 <= rect_left;  t_s1 <= rect_top;
		r_s1 <= rect_right; b_s1 <= rect_bottom;
		a1_s1 <= DB'(line_b_y) - DB'(line_a_y);
		b1_s1 <= DB'(line_a_x) - DB'(line_b_x);
	end

	// stage 2: products, one multiplier each
	always_ff @(posedge clk) begin
		p_ax_s2  <= PB'(a1_s1) * PB'(ax_s1);
		p_b1t_s2 <= PB'(b1_s1) * (PB'(ay_s1) - PB'(t_s1));
		p_b1b_s2 <= PB'(b1_s1) * (PB'(ay_s1) - PB'(b_s1));
		p_b1y_s2 <= PB'(b1_s1) * PB'(ay_s1);
		p_a1l_s2 <= PB'(a1_s1) * (PB'(ax_s1) - PB'(l_s1));
		p_a1r_s2 <= PB'(a1_s1) * (PB'(ax_s1) - PB'(r_s1));
		a1_s2 <= a1_s1; b1_s2 <= b1_s1;
		l_s2 <= l_s1; t_s2 <= t_s1; r_s2 <= r_s1; b_s2 <= b_s1;
		eh_s2 <= (l_s1 != r_s1);
		ev_s2 <= (t_s1 != b_s1);
	end

	// numerators feed the divider lanes
	assign nxt = NB'(p_ax_s2) + NB'(p_b1t_s2);
	assign nxb = NB'(p_ax_s2) + NB'(p_b1b_s2);
	assign nyl = NB'(p_a1l_s2) + NB'(p_b1y_s2);
	assign nyr = NB'(p_a1r_s2) + NB'(p_b1y_s2);

	lri_edge #(.NB(NB), .DB(DB), .CB(CB)) u_top (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .num(nxt), .den(a1_s2),
		.lo(l_s2), .hi(r_s2), .en(eh_s2), .out_vld(ov[0]), .hit(oh[0]));
	lri_edge #(.NB(NB), .DB(DB), .CB(CB)) u_bot (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .num(nxb), .den(a1_s2),
		.lo(l_s2), .hi(r_s2), .en(eh_s2), .out_vld(ov[1]), .hit(oh[1]));
	lri_edge #(.NB(NB), .DB(DB), .CB(CB)) u_lft (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .num(nyl), .den(b1_s2),
		.lo(t_s2), .hi(b_s2), .en(ev_s2), .out_vld(ov[2]), .hit(oh[2]));
	lri_edge #(.NB(NB), .DB(DB), .CB(CB)) u_rgt (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .num(nyr), .den(b1_s2),
		.lo(t_s2), .hi(b_s2), .en(ev_s2), .out_vld(ov[3]), .hit(oh[3]));

	assign done = ov[0];
	assign hit = |oh;

	// lanes stay in lockstep
	a_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(ov[0] == ov[1]) && (ov[0] == ov[2]) && (ov[0] == ov[3]))
		else $error("edge lanes out of step");
	a_s2: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> v_s1)
		else $error("request lost at stage 1");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit)
		else $error("hit without done");
endmodule
